@@ rtl/core/fqsr_pkg.sv @@
package fqsr_pkg;

  // Beat field widths
  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned PosWidth    = 4;

  // Packed beat widths, padded to whole bytes
  localparam int unsigned InBeatBits  = CmdWidth + ValueWidth;
  localparam int unsigned InTdataW    = ((InBeatBits + 7) / 8) * 8;
  localparam int unsigned OutBeatBits = StatusWidth + 2 * ValueWidth + CountWidth + 1 + PosWidth;
  localparam int unsigned OutTdataW   = ((OutBeatBits + 7) / 8) * 8;

  // Command codes
  localparam logic [CmdWidth-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_POP     = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_SEARCH  = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_REVERSE = 3'd4;
  localparam logic [CmdWidth-1:0] CMD_CLEAR   = 3'd5;

  // Status codes
  localparam logic [StatusWidth-1:0] ST_OK         = 3'd0;
  localparam logic [StatusWidth-1:0] ST_POP_EMPTY  = 3'd1;
  localparam logic [StatusWidth-1:0] ST_PUSH_FULL  = 3'd2;
  localparam logic [StatusWidth-1:0] ST_CLR_EMPTY  = 3'd3;
  localparam logic [StatusWidth-1:0] ST_NO_REVERSE = 3'd4;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_RDF  = 5'b00100,
    S_RDB  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

endpackage

@@ rtl/core/fifo_queue_with_search_reverse.sv @@
// Bounded FIFO queue with search and reverse, held in a ring memory.
// Input channel s_axis: one beat is one command (push, pop, peek, search,
// reverse, clear) with a value; commands 6 and 7 act as peek.
// Output channel m_axis: exactly one result beat per command, carrying the
// status, the front and back values after the command, the entry count and
// the search hit flag and position.
// Flow: a non-search command, once accepted, reads the front, then reads
// the back, then loads the result (states S_RDF, S_RDB, S_FIN). A search
// first walks the entries from the front in S_SRCH, comparing each with
// the key, and stops at the first hit or after the last entry. The entry
// memory has a single read port, so these reads run one after another. One
// command is in work at a time; the next one is taken once the result sits
// in the output register.
// Reset empties the queue and clears the direction flag; memory contents
// are not cleared and need no sweep.
// A stalled receiver holds the result beat in the output register; a new
// command can run meanwhile and waits at its final step until the held beat
// is taken.
module fifo_queue_with_search_reverse #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // cmd [2:0], value [34:3], zero pad [39:35]
  input  logic [fqsr_pkg::InTdataW-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status [2:0], front_value [34:3], back_value [66:35], count [71:67],
  // found [72], position [76:73], zero pad [79:77]
  output logic [fqsr_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DepthW = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [IW-1:0] LastSlot = IW'(DEPTH - 1);
  localparam int unsigned VW = fqsr_pkg::ValueWidth;

  // Ring slot of an offset from head, wrapped by one compare and subtract
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + (IW + 1)'(off);
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[IW-1:0];
  endfunction

  // Physical slot of the entry at a position from the front
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] cnt,
                                            input logic          rev,
                                            input logic [CW-1:0] pos);
    logic [CW-1:0] off;
    off = rev ? (cnt - CW'(1) - pos) : pos;
    return wrap_add(head, off);
  endfunction

  fqsr_pkg::state_e state_q, state_d;
  logic [IW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             rev_q, rev_d;
  logic [fqsr_pkg::StatusWidth-1:0] status_q, status_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic             found_q, found_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    pend_pos_q, pend_pos_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic             m_valid_q, m_valid_d;
  logic [fqsr_pkg::OutTdataW-1:0] m_data_q, m_data_d;

  logic [fqsr_pkg::CmdWidth-1:0] in_cmd;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [VW-1:0]         out_front;
  logic [VW-1:0]         out_back;

  assign in_cmd = s_axis_tdata_i[fqsr_pkg::CmdWidth-1:0];
  assign in_val = DATA_WIDTH'(s_axis_tdata_i[fqsr_pkg::InBeatBits-1:fqsr_pkg::CmdWidth]);

  assign s_axis_tready_o = (state_q == fqsr_pkg::S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  fqsr_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_val),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Select the read slot for the current step
  always_comb begin
    case (state_q)
      fqsr_pkg::S_SRCH: raddr = slot_of(head_q, cnt_q, rev_q, idx_q);
      fqsr_pkg::S_RDF:  raddr = slot_of(head_q, cnt_q, rev_q, '0);
      fqsr_pkg::S_RDB,
      fqsr_pkg::S_FIN:  raddr = slot_of(head_q, cnt_q, rev_q, cnt_q - CW'(1));
      default:          raddr = '0;
    endcase
  end

  // Zero the end values of an empty queue
  assign out_front = (cnt_q != '0) ? VW'(front_q) : '0;
  assign out_back  = (cnt_q != '0) ? VW'(rdata) : '0;

  // Sequencer: update on accept, walk for search, read both ends, load result
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    rev_d      = rev_q;
    status_d   = status_q;
    key_d      = key_q;
    found_d    = found_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_pos_d = pend_pos_q;
    front_d    = front_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    we         = 1'b0;
    waddr      = '0;

    case (state_q)
      fqsr_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          status_d = fqsr_pkg::ST_OK;
          key_d    = in_val;
          found_d  = 1'b0;
          pos_d    = '0;
          idx_d    = '0;
          pend_d   = 1'b0;
          state_d  = fqsr_pkg::S_RDF;
          case (in_cmd)
            fqsr_pkg::CMD_PUSH: begin
              if (cnt_q == DepthC) begin
                status_d = fqsr_pkg::ST_PUSH_FULL;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CW'(1);
                if (rev_q) begin
                  head_d = (head_q == '0) ? LastSlot : head_q - IW'(1);
                  waddr  = head_d;
                end else begin
                  waddr = wrap_add(head_q, cnt_q);
                end
              end
            end
            fqsr_pkg::CMD_POP: begin
              if (cnt_q == '0) begin
                status_d = fqsr_pkg::ST_POP_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (!rev_q) begin
                  head_d = wrap_add(head_q, CW'(1));
                end
              end
            end
            fqsr_pkg::CMD_SEARCH: begin
              if (cnt_q != '0) begin
                state_d = fqsr_pkg::S_SRCH;
              end
            end
            fqsr_pkg::CMD_REVERSE: begin
              if (cnt_q < CW'(2)) begin
                status_d = fqsr_pkg::ST_NO_REVERSE;
              end else begin
                rev_d = !rev_q;
              end
            end
            fqsr_pkg::CMD_CLEAR: begin
              if (cnt_q == '0) begin
                status_d = fqsr_pkg::ST_CLR_EMPTY;
              end else begin
                cnt_d  = '0;
                head_d = '0;
                rev_d  = 1'b0;
              end
            end
            default: begin
              status_d = fqsr_pkg::ST_OK;
            end
          endcase
        end
      end
      fqsr_pkg::S_SRCH: begin
        // Issue the next read while comparing the previous one
        if (idx_q < cnt_q) begin
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
          pend_pos_d = idx_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (rdata == key_q)) begin
          found_d = 1'b1;
          pos_d   = pend_pos_q;
          pend_d  = 1'b0;
          state_d = fqsr_pkg::S_RDF;
        end else if (idx_q >= cnt_q) begin
          state_d = fqsr_pkg::S_RDF;
        end
      end
      fqsr_pkg::S_RDF: begin
        state_d = fqsr_pkg::S_RDB;
      end
      fqsr_pkg::S_RDB: begin
        front_d = rdata;
        state_d = fqsr_pkg::S_FIN;
      end
      fqsr_pkg::S_FIN: begin
        // Hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = fqsr_pkg::OutTdataW'({
            fqsr_pkg::PosWidth'(pos_q),
            found_q,
            fqsr_pkg::CountWidth'(cnt_q),
            out_back,
            out_front,
            status_q
          });
          state_d = fqsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fqsr_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fqsr_pkg::S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      rev_q     <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      rev_q     <= rev_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    key_q      <= key_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    pend_pos_q <= pend_pos_d;
    front_q    <= front_d;
    m_data_q   <= m_data_d;
  end

endmodule

@@ rtl/core/fqsr_store.sv @@
module fqsr_store #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
